// ===== rtl/wap_pkg.sv =====
package wap_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COL,
    ST_SUM,
    ST_MUL1,
    ST_MUL2,
    ST_ACC,
    ST_OUT
  } state_t;

  localparam logic OP_COEF   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [2:0] REG_PLANE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_PLANE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_NUM_CHANNELS = 3'd2;
  localparam logic [2:0] REG_POOL_WIDTH   = 3'd3;
  localparam logic [2:0] REG_POOL_HEIGHT  = 3'd4;
  localparam logic [2:0] REG_STEP_X       = 3'd5;
  localparam logic [2:0] REG_STEP_Y       = 3'd6;
  localparam logic [2:0] REG_AREA_RECIP   = 3'd7;

  // Quotient of an 8-bit value by a step of one to four; a third is taken as a
  // multiply by 171/512, exact over the whole 8-bit range.
  function automatic logic [7:0] div_small(input logic [7:0] v, input logic [2:0] s);
    logic [16:0] m;
    m = 17'(v) * 17'd171;
    unique case (s)
      3'd1:    return v;
      3'd2:    return v >> 1;
      3'd3:    return m[16:9];
      default: return v >> 2;
    endcase
  endfunction

endpackage

// ===== rtl/wap_ram.sv =====
module wap_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/weighted_average_pool_stream.sv =====
// Average pooling over a stream of feature-map samples, with a weight and a
// bias for each channel. Input items arrive on the s_axis group: tuser low
// loads one channel's weight and bias, tuser high carries one sample. Samples
// come in raster order, one channel plane after another. Each sample that
// completes a pooling window gives one result item on the m_axis group, with
// tlast set on the final window of a frame. Registers are to be written
// through the cfg port only while no item is in flight; the block does not
// enforce this. They reset to an 8 by 8 plane, one channel, a 2 by 2 window
// with stride 2 and a reciprocal of one quarter. For a sample, the earlier
// rows of its column are read from the row memory one per cycle on its single
// read port and summed; a sample that closes a window then goes through two
// multiply stages, a rounding add and the output load.
// The result sits in an output register; a new item is taken while it waits,
// and the block holds only when a second result is ready before the first has
// been taken. Reset clears the counters and the output valid flag; the row and
// coefficient memories are not cleared, so coefficients must be loaded
// before the first sample that uses them.
module weighted_average_pool_stream
  import wap_pkg::*;
#(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_POOL     = 4,
  parameter int MAX_CHANNELS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // sample, coef_channel, weight, bias, zero pad
  input  logic        s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // value, channel, out_x, out_y, zero pad
  output logic        m_axis_tlast,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int ROW_SLOTS = (MAX_POOL > 1) ? MAX_POOL - 1 : 1;
  localparam int SLOT_W    = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int RAW       = $clog2(MAX_WIDTH * ROW_SLOTS);
  localparam int CW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int KW        = $clog2(MAX_POOL + 1);
  localparam int CS_W      = 16 + $clog2(MAX_POOL);
  localparam int SUM_W     = 16 + 2 * $clog2(MAX_POOL);
  localparam int P1_W      = SUM_W + 16;
  localparam int HI_W      = SUM_W + 17;
  localparam int ACC_W     = P1_W + 18;
  localparam int RW        = ACC_W - 30;
  localparam int CS_N      = (MAX_POOL > 1) ? MAX_POOL - 1 : 1;
  localparam int W_MAX     = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int C_MAX     = (MAX_CHANNELS < 64) ? MAX_CHANNELS : 64;
  localparam int P_CLAMP   = (MAX_POOL < 7) ? MAX_POOL : 7;

  logic [8:0]  plane_width;
  logic [8:0]  plane_height;
  logic [6:0]  num_channels;
  logic [2:0]  pool_width;
  logic [2:0]  pool_height;
  logic [2:0]  step_x;
  logic [2:0]  step_y;
  logic [15:0] area_recip;

  logic [8:0] wd;
  logic [8:0] ht;
  logic [6:0] nc;
  logic [2:0] pw;
  logic [2:0] ph;
  logic [2:0] sx;
  logic [2:0] sy;

  state_t state;
  state_t state_next;

  logic [7:0]        col_count;
  logic [7:0]        row_count;
  logic [5:0]        plane_count;
  logic [COL_W-1:0]  col;
  logic [SLOT_W-1:0] slot;
  logic [CW-1:0]     pmod;

  logic [7:0]         c_l;
  logic [7:0]         r_l;
  logic [5:0]         p_l;
  logic [COL_W-1:0]   col_l;
  logic [SLOT_W-1:0]  slot_l;
  logic signed [15:0] sample_l;

  logic [KW-1:0]          kk;
  logic                   pend;
  logic                   use_rd;
  logic signed [CS_W-1:0] colsum;
  logic signed [CS_W-1:0] csum [CS_N];

  logic signed [SUM_W-1:0] sum;
  logic [7:0]              res_x;
  logic [7:0]              res_y;
  logic                    res_last;
  logic signed [P1_W-1:0]  p1;
  logic signed [HI_W-1:0]  hi_p;
  logic [31:0]             lo_p;
  logic signed [ACC_W-1:0] acc;

  logic        m_valid;
  logic [15:0] m_value;
  logic [5:0]  m_channel;
  logic [7:0]  m_x;
  logic [7:0]  m_y;
  logic        m_last;

  logic                  accept;
  logic                  issue;
  logic                  row_re;
  logic [RAW-1:0]        row_raddr;
  logic                  row_we;
  logic [RAW-1:0]        row_waddr;
  logic [15:0]           row_rdata;
  logic                  coef_we;
  logic                  coef_re;
  logic [31:0]           coef_rdata;
  logic [SLOT_W:0]       rd_slot_sum;
  logic [SLOT_W-1:0]     rd_slot;
  logic signed [SUM_W-1:0] sum_calc;
  logic                  out_load;

  logic [7:0]  x0;
  logic [7:0]  y0;
  logic [7:0]  qx;
  logic [7:0]  qy;
  logic [10:0] rx_prod;
  logic [10:0] ry_prod;
  logic [10:0] lim_x;
  logic [10:0] lim_y;
  logic [8:0]  wd_pw;
  logic [8:0]  ht_ph;
  logic        win_ok;
  logic        last_calc;
  logic signed [RW-1:0] res_full;

  // Register clamps
  always_comb begin
    wd = (plane_width == 9'd0) ? 9'd1 :
         ((plane_width > 9'(W_MAX)) ? 9'(W_MAX) : plane_width);
    ht = (plane_height == 9'd0) ? 9'd1 :
         ((plane_height > 9'd256) ? 9'd256 : plane_height);
    nc = (num_channels == 7'd0) ? 7'd1 :
         ((num_channels > 7'(C_MAX)) ? 7'(C_MAX) : num_channels);
    pw = (pool_width == 3'd0) ? 3'd1 :
         ((pool_width > 3'(P_CLAMP)) ? 3'(P_CLAMP) : pool_width);
    ph = (pool_height == 3'd0) ? 3'd1 :
         ((pool_height > 3'(P_CLAMP)) ? 3'(P_CLAMP) : pool_height);
    sx = (step_x == 3'd0) ? 3'd1 : ((step_x > 3'd4) ? 3'd4 : step_x);
    sy = (step_y == 3'd0) ? 3'd1 : ((step_y > 3'd4) ? 3'd4 : step_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_width  <= 9'd8;
      plane_height <= 9'd8;
      num_channels <= 7'd1;
      pool_width   <= 3'd2;
      pool_height  <= 3'd2;
      step_x       <= 3'd2;
      step_y       <= 3'd2;
      area_recip   <= 16'd16384;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_PLANE_WIDTH:  plane_width  <= cfg_data[8:0];
        REG_PLANE_HEIGHT: plane_height <= cfg_data[8:0];
        REG_NUM_CHANNELS: num_channels <= cfg_data[6:0];
        REG_POOL_WIDTH:   pool_width   <= cfg_data[2:0];
        REG_POOL_HEIGHT:  pool_height  <= cfg_data[2:0];
        REG_STEP_X:       step_x       <= cfg_data[2:0];
        REG_STEP_Y:       step_y       <= cfg_data[2:0];
        REG_AREA_RECIP:   area_recip   <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tuser == OP_SAMPLE) begin
          state_next = ST_COL;
        end
      end
      ST_COL: begin
        if (!issue) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM:  state_next = win_ok ? ST_MUL1 : ST_IDLE;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_ACC;
      ST_ACC:  state_next = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_axis_tready = 1'b0;
    row_re        = 1'b0;
    row_we        = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_COL:  row_re = issue;
      ST_SUM:  row_we = 1'b1;
      ST_OUT:  out_load = !m_valid || m_axis_tready;
      default: ;
    endcase
  end

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign coef_we = accept && s_axis_tuser == OP_COEF &&
                   32'(s_axis_tdata[21:16]) < 32'(MAX_CHANNELS);
  assign coef_re = accept && s_axis_tuser == OP_SAMPLE;

  assign issue       = 32'(kk) < 32'(ph);
  assign rd_slot_sum = (SLOT_W + 1)'(slot_l) + (SLOT_W + 1)'(ROW_SLOTS) - (SLOT_W + 1)'(kk);
  assign rd_slot     = (rd_slot_sum >= (SLOT_W + 1)'(ROW_SLOTS)) ?
                       SLOT_W'(rd_slot_sum - (SLOT_W + 1)'(ROW_SLOTS)) :
                       SLOT_W'(rd_slot_sum);
  assign row_raddr   = RAW'(32'(rd_slot) * 32'(MAX_WIDTH) + 32'(col_l));
  assign row_waddr   = RAW'(32'(slot_l) * 32'(MAX_WIDTH) + 32'(col_l));

  wap_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH * ROW_SLOTS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (sample_l),
    .re    (row_re),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  wap_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (CW'(s_axis_tdata[21:16])),
    .wdata ({s_axis_tdata[53:38], s_axis_tdata[37:22]}),
    .re    (coef_re),
    .raddr (pmod),
    .rdata (coef_rdata)
  );

  // Window position, last-window flag, sum of the column sums and result slice
  always_comb begin
    sum_calc = SUM_W'(colsum);
    for (int k = 1; k < MAX_POOL; k++) begin
      if (k < 32'(pw)) begin
        sum_calc = sum_calc + SUM_W'(csum[(k > 0) ? k - 1 : 0]);
      end
    end
    x0        = c_l + 8'd1 - 8'(pw);
    y0        = r_l + 8'd1 - 8'(ph);
    qx        = div_small(x0, sx);
    qy        = div_small(y0, sy);
    rx_prod   = 11'(qx) * 11'(sx);
    ry_prod   = 11'(qy) * 11'(sy);
    wd_pw     = wd - 9'(pw);
    ht_ph     = ht - 9'(ph);
    lim_x     = 11'(div_small(wd_pw[7:0], sx)) * 11'(sx);
    lim_y     = 11'(div_small(ht_ph[7:0], sy)) * 11'(sy);
    win_ok    = (9'(r_l) + 9'd1 >= 9'(ph)) && (9'(c_l) + 9'd1 >= 9'(pw)) &&
                (rx_prod == 11'(x0)) && (ry_prod == 11'(y0));
    last_calc = (wd >= 9'(pw)) && (ht >= 9'(ph)) && (7'(p_l) + 7'd1 >= nc) &&
                (lim_x == 11'(x0)) && (lim_y == 11'(y0));
    res_full  = acc[ACC_W-1:30];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      col_count   <= '0;
      row_count   <= '0;
      plane_count <= '0;
      col         <= '0;
      slot        <= '0;
      pmod        <= '0;
      pend        <= 1'b0;
      m_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (coef_re) begin
        if (9'(col_count) + 9'd1 >= wd) begin
          col_count <= '0;
          col       <= '0;
          if (9'(row_count) + 9'd1 >= ht) begin
            row_count <= '0;
            slot      <= '0;
            if (7'(plane_count) + 7'd1 >= nc) begin
              plane_count <= '0;
              pmod        <= '0;
            end else begin
              plane_count <= plane_count + 6'd1;
              pmod <= (32'(pmod) == MAX_CHANNELS - 1) ? '0 : pmod + CW'(1);
            end
          end else begin
            row_count <= row_count + 8'd1;
            slot <= (32'(slot) == ROW_SLOTS - 1) ? '0 : slot + SLOT_W'(1);
          end
        end else begin
          col_count <= col_count + 8'd1;
          col <= (32'(col) == MAX_WIDTH - 1) ? '0 : col + COL_W'(1);
        end
        pend <= 1'b0;
      end else if (state == ST_COL) begin
        pend <= issue;
      end
      if (out_load) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (coef_re) begin
      c_l      <= col_count;
      r_l      <= row_count;
      p_l      <= plane_count;
      col_l    <= col;
      slot_l   <= slot;
      sample_l <= $signed(s_axis_tdata[15:0]);
      colsum   <= CS_W'($signed(s_axis_tdata[15:0]));
      kk       <= KW'(1);
    end
    if (state == ST_COL) begin
      if (issue) begin
        kk     <= kk + KW'(1);
        use_rd <= 32'(r_l) >= 32'(kk);
      end
      if (pend && use_rd) begin
        colsum <= colsum + CS_W'($signed(row_rdata));
      end
    end
    if (state == ST_SUM) begin
      csum[0] <= colsum;
      for (int i = 1; i < CS_N; i++) begin
        csum[i] <= csum[i-1];
      end
      sum      <= sum_calc;
      res_x    <= qx;
      res_y    <= qy;
      res_last <= last_calc;
    end
    if (state == ST_MUL1) begin
      p1 <= P1_W'(sum) * P1_W'($signed(coef_rdata[15:0]));
    end
    if (state == ST_MUL2) begin
      hi_p <= HI_W'($signed(p1[P1_W-1:16])) * HI_W'($signed({1'b0, area_recip}));
      lo_p <= 32'(p1[15:0]) * 32'(area_recip);
    end
    if (state == ST_ACC) begin
      acc <= (ACC_W'(hi_p) <<< 16) + ACC_W'(lo_p) +
             (ACC_W'($signed(coef_rdata[31:16])) <<< 30) + (ACC_W'(1) <<< 29);
    end
    if (out_load) begin
      if (res_full > RW'(32767)) begin
        m_value <= 16'h7FFF;
      end else if (res_full < -RW'(32768)) begin
        m_value <= 16'h8000;
      end else begin
        m_value <= res_full[15:0];
      end
      m_channel <= p_l;
      m_x       <= res_x;
      m_y       <= res_y;
      m_last    <= res_last;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {2'b00, m_y, m_x, m_channel, m_value};
  assign m_axis_tlast  = m_last;

`ifndef ASSERT_OFF
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && m_valid && !m_axis_tready) |=> state == ST_OUT)
    else $error("pending result overwritten");

  a_rise_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == ST_OUT)
    else $error("result shown without a finished window");

  a_col_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COL && pend) |=> state == ST_COL || state == ST_SUM)
    else $error("row read left before its data arrived");
`endif

endmodule
